/* hdl/gf2me_pkg.sv */
// Shared types for the GF(2) polynomial modular exponentiation block.
// No dependencies; imported by gf2me_mulmod and gf2m_modular_exponentiation.
package gf2me_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

/* hdl/gf2m_modular_exponentiation.sv */
// Top level: GF(2)[X] modular exponentiation, square and multiply always.
// Depends on gf2me_pkg and gf2me_mulmod.
//
// Usage:
//   Input channel s_valid/s_ready carries s_base and s_exponent; the result
//   channel m_valid/m_ready carries m_power = base^exponent mod modulus.
//   The modulus register is written through cfg_valid/cfg_ready/cfg_modulus;
//   the user must write it only while idle; the block does not enforce this.
//   cfg_ready is always high. Reset value is 283. One item is in work at a
//   time; s_ready is high only while idle. All EXP_BITS exponent bits are
//   scanned from the top; leading zeros keep the running value at 1. One
//   bit-serial multiplier is shared: a first pass reduces the base, then
//   each exponent bit takes a square and a multiply. After the last
//   multiply the result passes through ST_DONE into the output register
//   and the block returns to idle; a modulus of degree zero skips the
//   multiplier and gives 0 the same way.
//   The result is held in an output register; the next item is accepted
//   while it waits. If the receiver still stalls when the next result is
//   ready, the block holds that result internally until the transfer.
//   Synchronous active-low reset returns to idle with no result pending.
module gf2m_modular_exponentiation import gf2me_pkg::*; #(
    parameter int EXP_BITS   = 32,
    parameter int MAX_DEGREE = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [MAX_DEGREE:0]   cfg_modulus,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MAX_DEGREE-1:0] s_base,
    input  logic [EXP_BITS-1:0]   s_exponent,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MAX_DEGREE-1:0] m_power
);

    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int EW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam logic [MAX_DEGREE:0] MOD_RESET = (MAX_DEGREE+1)'(283);

    typedef enum logic [2:0] {ST_IDLE, ST_RBASE, ST_SQ, ST_MUL, ST_DONE} state_t;

    state_t                state_reg;
    logic [MAX_DEGREE:0]   mod_reg;
    logic [MAX_DEGREE:0]   p_reg;
    logic [DW-1:0]         d_reg;
    logic [DW-1:0]         deg;
    logic [MAX_DEGREE-1:0] base_reg;
    logic [EXP_BITS-1:0]   exp_reg;
    logic [EW-1:0]         bit_reg;
    logic [MAX_DEGREE-1:0] r_reg;
    logic [MAX_DEGREE-1:0] sq_reg;
    logic [MAX_DEGREE-1:0] op_a_reg;
    logic [MAX_DEGREE-1:0] op_b_reg;
    logic                  start_reg;
    logic                  start_next;
    logic [MAX_DEGREE-1:0] res_reg;
    logic                  m_valid_reg;
    logic [MAX_DEGREE-1:0] m_power_reg;
    logic [MAX_DEGREE-1:0] r_next;
    logic [MAX_DEGREE-1:0] mm_result;
    mm_status_t            mm_status;

    always_comb begin
        deg = '0;
        for (int k = 1; k <= MAX_DEGREE; k++) begin
            if (mod_reg[k]) begin
                deg = DW'(k);
            end
        end
    end

    gf2me_mulmod #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_mulmod (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (start_reg),
        .a      (op_a_reg),
        .b      (op_b_reg),
        .p      (p_reg),
        .d      (d_reg),
        .status (mm_status),
        .result (mm_result)
    );

    assign r_next = exp_reg[EXP_BITS-1] ? mm_result : sq_reg;

    always_comb begin
        unique case (state_reg)
            ST_IDLE:         start_next = s_valid && (deg != '0);
            ST_RBASE, ST_SQ: start_next = mm_status.done;
            ST_MUL:          start_next = mm_status.done && (bit_reg != '0);
            default:         start_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mod_reg     <= MOD_RESET;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= start_next;
            if (cfg_valid) begin
                mod_reg <= cfg_modulus;
            end
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        p_reg   <= mod_reg;
                        d_reg   <= deg;
                        exp_reg <= s_exponent;
                        bit_reg <= EW'(EXP_BITS - 1);
                        r_reg   <= MAX_DEGREE'(1);
                        if (deg == '0) begin
                            res_reg   <= '0;
                            state_reg <= ST_DONE;
                        end else begin
                            op_a_reg  <= MAX_DEGREE'(1);
                            op_b_reg  <= s_base;
                            state_reg <= ST_RBASE;
                        end
                    end
                end
                ST_RBASE: begin
                    if (mm_status.done) begin
                        base_reg  <= mm_result;
                        op_a_reg  <= r_reg;
                        op_b_reg  <= r_reg;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (mm_status.done) begin
                        sq_reg    <= mm_result;
                        op_a_reg  <= mm_result;
                        op_b_reg  <= base_reg;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mm_status.done) begin
                        r_reg   <= r_next;
                        exp_reg <= exp_reg << 1;
                        if (bit_reg == '0) begin
                            res_reg   <= r_next;
                            state_reg <= ST_DONE;
                        end else begin
                            bit_reg   <= bit_reg - 1'b1;
                            op_a_reg  <= r_next;
                            op_b_reg  <= r_next;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_power_reg <= res_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !mm_status.busy;
    assign m_valid   = m_valid_reg;
    assign m_power   = m_power_reg;

endmodule

/* hdl/gf2me_mulmod.sv */
// Bit-serial GF(2) modular multiplier: result = a * b mod p, MSB of b first.
// Operand a must already be reduced below degree d. Depends on gf2me_pkg.
module gf2me_mulmod import gf2me_pkg::*; #(
    parameter int MAX_DEGREE = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [MAX_DEGREE-1:0]                a,
    input  logic [MAX_DEGREE-1:0]                b,
    input  logic [MAX_DEGREE:0]                  p,
    input  logic [$clog2(MAX_DEGREE+1)-1:0]      d,
    output mm_status_t                           status,
    output logic [MAX_DEGREE-1:0]                result
);

    localparam int CW = $clog2(MAX_DEGREE);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                state_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [MAX_DEGREE-1:0] acc_reg, acc_next;
    logic [MAX_DEGREE-1:0] a_reg;
    logic [MAX_DEGREE-1:0] b_reg;
    logic [MAX_DEGREE:0]   t;

    always_comb begin
        t = {acc_reg, 1'b0};
        if (t[d]) begin
            t = t ^ p;
        end
        if (b_reg[MAX_DEGREE-1]) begin
            t = t ^ {1'b0, a_reg};
        end
        acc_next = t[MAX_DEGREE-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= (state_reg == ST_RUN) && (cnt_reg == '0);
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        acc_reg   <= '0;
                        a_reg     <= a;
                        b_reg     <= b;
                        cnt_reg   <= CW'(MAX_DEGREE - 1);
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    acc_reg <= acc_next;
                    b_reg   <= {b_reg[MAX_DEGREE-2:0], 1'b0};
                    if (cnt_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign status.busy = (state_reg == ST_RUN);
    assign status.done = done_reg;
    assign result      = acc_reg;

endmodule
